// ===== hdl/iabm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iabm_pkg
// Types and codes shared by the action binding mapper.
// ----------------------------------------------------------------------------
package iabm_pkg;

  localparam logic [8:0] Q_ONE = 9'd256;

  typedef enum logic [3:0] {
    REQ_KEY        = 4'd0,
    REQ_MOUSE      = 4'd1,
    REQ_FOCUS_LOST = 4'd2,
    REQ_FRAME_END  = 4'd3,
    REQ_ADD_ACT    = 4'd4,
    REQ_REM_ACT    = 4'd5,
    REQ_DEADZONE   = 4'd6,
    REQ_ADD_BIND   = 4'd7,
    REQ_REM_BIND   = 4'd8,
    REQ_CLR_BIND   = 4'd9,
    REQ_VIRTUAL    = 4'd10,
    REQ_QUERY      = 4'd11
  } req_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_ACTION = 3'd1;
  localparam logic [2:0] ST_EXISTS    = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic       kind;
    logic [7:0] code;
    logic [8:0] strength;
    logic       active;
  } bind_t;

  typedef struct packed {
    logic jr;
    logic jp;
    logic pr;
  } flags_t;

  typedef struct packed {
    flags_t     flags;
    logic [8:0] strength;
    logic [8:0] virt;
    logic [8:0] deadzone;
  } act_t;

  typedef struct packed {
    req_t       req;
    logic       kind;
    logic [7:0] code;
    logic       down;
    logic [8:0] val;
    logic       sweep;
    logic       exists;
    logic       inr;
  } row_cmd_t;

  typedef struct packed {
    logic       act_we;
    logic       bind_we;
    logic       set_valid;
    logic       clr_valid;
    logic [2:0] status;
    logic       exists_after;
  } row_res_t;

endpackage
`default_nettype wire

// ===== hdl/input_action_binding_mapper.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sequence: table edits and queries read the addressed row in READ, then
//   apply the request and register the result in EXEC; key, mouse, focus-lost
//   and frame-end requests first walk the action rows in SWEEP, one row read
//   per cycle, then pass DRAIN, READ and EXEC. One request at a time; the
//   next is taken once the result is registered, while that result may wait.
// Reset: clears the action valid bits and control; no memory clearing pass.
// ----------------------------------------------------------------------------
// input_action_binding_mapper
// Action table with key and mouse bindings, held in two row memories.
// ----------------------------------------------------------------------------
module input_action_binding_mapper #(
  parameter int ACTIONS             = 32,
  parameter int BINDINGS_PER_ACTION = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [3:0] in_req_type,
  input  wire logic [4:0] in_action_index,
  input  wire logic       in_source_kind,
  input  wire logic [7:0] in_code,
  input  wire logic       in_is_down,
  input  wire logic [8:0] in_value,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_status,
  output logic            out_pressed,
  output logic            out_just_pressed,
  output logic            out_just_released,
  output logic [8:0]      out_strength_out,
  output logic [8:0]      out_deadzone_out
);

  localparam int BPA = BINDINGS_PER_ACTION;
  localparam int AW  = (ACTIONS > 1) ? $clog2(ACTIONS) : 1;
  localparam int EW  = $bits(iabm_pkg::bind_t) * BPA;
  localparam int BW  = EW + BPA;
  localparam int XW  = (AW > 5) ? AW + 1 : 6;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SWEEP = 5'b00010,
    S_DRAIN = 5'b00100,
    S_READ  = 5'b01000,
    S_EXEC  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // request hold
  iabm_pkg::req_t req_r;
  logic [4:0]     idx_r;
  logic           kind_r;
  logic [7:0]     code_r;
  logic           down_r;
  logic [8:0]     val_r;

  logic [AW-1:0]      cnt_r, cnt_nxt;
  logic               proc_v_r, proc_v_nxt;
  logic [AW-1:0]      proc_a_r, proc_a_nxt;
  logic [ACTIONS-1:0] act_valid_r;

  // row memories
  iabm_pkg::act_t act_mem [ACTIONS];
  logic [BW-1:0]  bind_mem [ACTIONS];
  iabm_pkg::act_t act_rd_r;
  logic [BW-1:0]  bind_rd_r;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;

  logic [AW-1:0] idx_a;
  logic          idx_inr;
  logic          accept;
  logic          fire_exec;
  logic          proc_sweep;

  iabm_pkg::row_cmd_t cmd;
  iabm_pkg::row_res_t res;
  iabm_pkg::act_t     act_new;
  logic [BPA-1:0]     mask_new;
  iabm_pkg::bind_t [BPA-1:0] ent_new;
  logic [AW-1:0]      wr_addr;
  logic               act_we;
  logic               bind_we;

  logic       out_valid_r;
  logic [2:0] status_r;
  logic       pressed_r, jp_r, jr_r;
  logic [8:0] strength_r, deadzone_r;

  assign idx_a   = AW'(idx_r);
  assign idx_inr = XW'(idx_r) < XW'(ACTIONS);

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state_r != S_IDLE);
  assign proc_sweep = proc_v_r && ((state_r == S_SWEEP) || (state_r == S_DRAIN));
  // hold the result in EXEC while the previous one has not been taken
  assign fire_exec  = (state_r == S_EXEC) && !(out_valid_r && out_stall);

  // Sequencer: walk all rows for broadcast requests, then read the addressed row.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    proc_v_nxt = 1'b0;
    proc_a_nxt = proc_a_r;
    rd_en      = 1'b0;
    rd_addr    = idx_a;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cnt_nxt = '0;
          if (in_req_type <= 4'(iabm_pkg::REQ_FRAME_END)) begin
            state_nxt = S_SWEEP;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_SWEEP: begin
        rd_en      = 1'b1;
        rd_addr    = cnt_r;
        proc_v_nxt = 1'b1;
        proc_a_nxt = cnt_r;
        cnt_nxt    = cnt_r + AW'(1);
        if (cnt_r == AW'(ACTIONS - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last row writes back here; read the addressed row only afterwards
        state_nxt = S_READ;
      end
      S_READ: begin
        rd_en     = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (fire_exec) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      proc_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      proc_v_r <= proc_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    proc_a_r <= proc_a_nxt;
    if (accept) begin
      req_r  <= iabm_pkg::req_t'(in_req_type);
      idx_r  <= in_action_index;
      kind_r <= in_source_kind;
      code_r <= in_code;
      down_r <= in_is_down;
      val_r  <= (in_value > iabm_pkg::Q_ONE) ? iabm_pkg::Q_ONE : in_value;
    end
  end

  // Row update: sweep rows or the addressed row, both from the read registers.
  always_comb begin
    cmd.req    = req_r;
    cmd.kind   = kind_r;
    cmd.code   = code_r;
    cmd.down   = down_r;
    cmd.val    = val_r;
    cmd.sweep  = proc_sweep;
    cmd.inr    = proc_sweep ? 1'b1 : idx_inr;
    cmd.exists = proc_sweep ? act_valid_r[proc_a_r] : (idx_inr && act_valid_r[idx_a]);
  end

  iabm_row #(
    .BPA (BPA)
  ) u_row (
    .cmd      (cmd),
    .act_in   (act_rd_r),
    .mask_in  (bind_rd_r[BW-1:EW]),
    .ent_in   (bind_rd_r[EW-1:0]),
    .act_out  (act_new),
    .mask_out (mask_new),
    .ent_out  (ent_new),
    .res      (res)
  );

  assign wr_addr = proc_sweep ? proc_a_r : idx_a;
  assign act_we  = (proc_sweep || fire_exec) && res.act_we;
  assign bind_we = (proc_sweep || fire_exec) && res.bind_we;

  always_ff @(posedge clk) begin
    if (act_we) begin
      act_mem[wr_addr] <= act_new;
    end
    if (bind_we) begin
      bind_mem[wr_addr] <= {mask_new, ent_new};
    end
    if (rd_en) begin
      act_rd_r  <= act_mem[rd_addr];
      bind_rd_r <= bind_mem[rd_addr];
    end
  end

  // Action valid bits: the only table state that reset clears.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_valid_r <= '0;
    end else if (fire_exec) begin
      if (res.set_valid) begin
        act_valid_r[idx_a] <= 1'b1;
      end else if (res.clr_valid) begin
        act_valid_r[idx_a] <= 1'b0;
      end
    end
  end

  // Result register: drop the beat once taken, load on EXEC.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire_exec) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_exec) begin
      status_r <= res.status;
      if (res.exists_after) begin
        pressed_r  <= act_new.flags.pr;
        jp_r       <= act_new.flags.jp;
        jr_r       <= act_new.flags.jr;
        strength_r <= act_new.strength;
        deadzone_r <= act_new.deadzone;
      end else begin
        pressed_r  <= 1'b0;
        jp_r       <= 1'b0;
        jr_r       <= 1'b0;
        strength_r <= '0;
        deadzone_r <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_pressed       = pressed_r;
  assign out_just_pressed  = jp_r;
  assign out_just_released = jr_r;
  assign out_strength_out  = strength_r;
  assign out_deadzone_out  = deadzone_r;

endmodule
`default_nettype wire

// ===== hdl/iabm_row.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iabm_row
// Modify one action row and its binding row; re-evaluate strength and flags.
// ----------------------------------------------------------------------------
module iabm_row #(
  parameter int BPA = 8
) (
  input  iabm_pkg::row_cmd_t           cmd,
  input  iabm_pkg::act_t               act_in,
  input  logic [BPA-1:0]               mask_in,
  input  iabm_pkg::bind_t [BPA-1:0]    ent_in,
  output iabm_pkg::act_t               act_out,
  output logic [BPA-1:0]               mask_out,
  output iabm_pkg::bind_t [BPA-1:0]    ent_out,
  output iabm_pkg::row_res_t           res
);

  logic [BPA-1:0] match;
  logic [BPA-1:0] first_hit;
  logic [BPA-1:0] first_free;
  logic           mkind;

  assign mkind = cmd.sweep ? (cmd.req == iabm_pkg::REQ_MOUSE) : cmd.kind;

  always_comb begin
    for (int i = 0; i < BPA; i++) begin
      match[i] = mask_in[i] && (ent_in[i].kind == mkind) && (ent_in[i].code == cmd.code);
    end
  end

  // lowest set bit
  assign first_hit  = match & (~match + BPA'(1));
  assign first_free = ~mask_in & (mask_in + BPA'(1));

  always_comb begin
    iabm_pkg::act_t act_n;
    logic           do_eval;
    logic           changed;
    logic [8:0]     s;
    logic           now;
    act_n   = act_in;
    mask_out = mask_in;
    ent_out  = ent_in;
    res      = '0;
    do_eval  = 1'b0;
    changed  = 1'b0;
    res.exists_after = cmd.exists;
    if (cmd.sweep) begin
      case (cmd.req)
        iabm_pkg::REQ_KEY, iabm_pkg::REQ_MOUSE: begin
          for (int i = 0; i < BPA; i++) begin
            if (match[i] && (ent_in[i].active != cmd.down)) begin
              ent_out[i].active = cmd.down;
              changed = 1'b1;
            end
          end
          do_eval     = changed;
          res.act_we  = cmd.exists && changed;
          res.bind_we = cmd.exists && changed;
        end
        iabm_pkg::REQ_FOCUS_LOST: begin
          for (int i = 0; i < BPA; i++) begin
            ent_out[i].active = 1'b0;
          end
          do_eval     = 1'b1;
          res.act_we  = cmd.exists;
          res.bind_we = cmd.exists;
        end
        iabm_pkg::REQ_FRAME_END: begin
          act_n.flags.jp = 1'b0;
          act_n.flags.jr = 1'b0;
          res.act_we     = cmd.exists;
        end
        default: begin
        end
      endcase
    end else begin
      case (cmd.req)
        iabm_pkg::REQ_KEY, iabm_pkg::REQ_MOUSE,
        iabm_pkg::REQ_FOCUS_LOST, iabm_pkg::REQ_FRAME_END: begin
          res.status = iabm_pkg::ST_OK;
        end
        iabm_pkg::REQ_ADD_ACT: begin
          if (!cmd.inr) begin
            res.status = iabm_pkg::ST_NO_ACTION;
          end else if (cmd.exists) begin
            res.status = iabm_pkg::ST_EXISTS;
          end else begin
            act_n          = '0;
            act_n.deadzone = cmd.val;
            mask_out       = '0;
            res.act_we     = 1'b1;
            res.bind_we    = 1'b1;
            res.set_valid  = 1'b1;
            res.exists_after = 1'b1;
          end
        end
        iabm_pkg::REQ_REM_ACT: begin
          if (!cmd.exists) begin
            res.status = iabm_pkg::ST_NO_ACTION;
          end else begin
            res.clr_valid    = 1'b1;
            res.exists_after = 1'b0;
          end
        end
        iabm_pkg::REQ_DEADZONE: begin
          if (!cmd.exists) begin
            res.status = iabm_pkg::ST_NO_ACTION;
          end else begin
            act_n.deadzone = cmd.val;
            do_eval        = 1'b1;
            res.act_we     = 1'b1;
          end
        end
        iabm_pkg::REQ_ADD_BIND: begin
          if (!cmd.exists) begin
            res.status = iabm_pkg::ST_NO_ACTION;
          end else if (|match) begin
            res.status = iabm_pkg::ST_EXISTS;
          end else if (&mask_in) begin
            res.status = iabm_pkg::ST_FULL;
          end else begin
            for (int i = 0; i < BPA; i++) begin
              if (first_free[i]) begin
                mask_out[i]         = 1'b1;
                ent_out[i].kind     = cmd.kind;
                ent_out[i].code     = cmd.code;
                ent_out[i].strength = cmd.val;
                ent_out[i].active   = cmd.down;
              end
            end
            do_eval     = 1'b1;
            res.act_we  = 1'b1;
            res.bind_we = 1'b1;
          end
        end
        iabm_pkg::REQ_REM_BIND: begin
          if (!cmd.exists) begin
            res.status = iabm_pkg::ST_NO_ACTION;
          end else if (!(|match)) begin
            res.status = iabm_pkg::ST_NOT_FOUND;
          end else begin
            mask_out    = mask_in & ~first_hit;
            do_eval     = 1'b1;
            res.act_we  = 1'b1;
            res.bind_we = 1'b1;
          end
        end
        iabm_pkg::REQ_CLR_BIND: begin
          if (!cmd.exists) begin
            res.status = iabm_pkg::ST_NO_ACTION;
          end else begin
            mask_out    = '0;
            do_eval     = 1'b1;
            res.act_we  = 1'b1;
            res.bind_we = 1'b1;
          end
        end
        iabm_pkg::REQ_VIRTUAL: begin
          if (!cmd.exists) begin
            res.status = iabm_pkg::ST_NO_ACTION;
          end else begin
            act_n.virt = cmd.val;
            do_eval    = 1'b1;
            res.act_we = 1'b1;
          end
        end
        default: begin
          res.status = cmd.exists ? iabm_pkg::ST_OK : iabm_pkg::ST_NO_ACTION;
        end
      endcase
    end

    // strength = max of virtual and active binding strengths
    s = act_n.virt;
    for (int i = 0; i < BPA; i++) begin
      if (mask_out[i] && ent_out[i].active && (ent_out[i].strength > s)) begin
        s = ent_out[i].strength;
      end
    end
    now = s > act_n.deadzone;
    if (do_eval) begin
      if (now && !act_in.flags.pr) begin
        act_n.flags.jp = 1'b1;
      end
      if (!now && act_in.flags.pr) begin
        act_n.flags.jr = 1'b1;
      end
      act_n.flags.pr = now;
      act_n.strength = s;
    end
    act_out = act_n;
  end

endmodule
`default_nettype wire
